@@ hw/rtl/thermal_code_average_calibrate_defines.svh @@
// Assertion macros for the thermal code averaging and calibration block.
// Included by the modules that carry concurrent assertions.
`ifndef THERMAL_CODE_AVERAGE_CALIBRATE_DEFINES_SVH
`define THERMAL_CODE_AVERAGE_CALIBRATE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCAC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
`define TCAC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCAC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TCAC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ hw/rtl/tcac_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the thermal code averaging and calibration block.
// No dependencies.
package tcac_pkg;

    localparam int CODE_W        = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CORR_W        = 13;
    localparam int DIV_NUM_W     = 33;
    localparam int DIV_DEN_W     = 21;
    localparam int TEMP_FRAC_BITS = 4;
    localparam int MDEG_PER_DEG  = 1000;
    localparam int DEG_OFFSET    = 100;

    localparam logic [20:0] CORR_A     = 21'd1230000;
    localparam logic [20:0] CORR_SCALE = 21'd1000000;
    localparam logic [5:0]  CORR_B     = 6'd37;

    typedef struct packed {
        logic              sensor_channel;
        logic [CODE_W-1:0] raw_code;
    } in_word_t;

    typedef struct packed {
        logic               done_channel;
        logic signed [31:0] channel_temp_mdeg;
        logic signed [31:0] max_temp_mdeg;
        logic               max_valid;
        logic               cal_error;
    } out_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_CODE_CH0,
        CFG_HIGH_CODE_CH0,
        CFG_LOW_CODE_CH1,
        CFG_HIGH_CODE_CH1,
        CFG_LOW_TEMP,
        CFG_HIGH_TEMP
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_LO,
        DIV_HI,
        DIV_CAVG,
        DIV_SLOPE
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_HI_GO,
        ST_HI_WAIT,
        ST_CA_GO,
        ST_CA_WAIT,
        ST_SLOPE_GO,
        ST_SLOPE_WAIT,
        ST_MUL,
        ST_ADD,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     mul;
        logic     add;
        logic     update;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic in_reading;
        logic div_busy;
        logic div_done;
        logic cal_err;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/tcac_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tcac_pkg.
module tcac_div
    import tcac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam int STEP_W = $clog2(DIV_NUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;

endmodule

@@ hw/rtl/tcac_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: per-channel accumulators, calibration registers, correction and
// interpolation arithmetic, output word register. Depends on tcac_pkg, tcac_div.
module tcac_datapath
    import tcac_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 8,
    parameter int NUM_CHANNELS        = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  in_word_t             sample,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_word_t            result,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int SUM_W = CODE_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic signed [33:0] T_MAX = 34'sd2147483647;
    localparam logic signed [33:0] T_MIN = -34'sd2147483648;
    // average by reciprocal multiplication, exact for any sum below 2**SUM_W
    localparam int AVG_SH     = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int AVG_PROD_W = SUM_W + AVG_SH + 1;
    localparam logic [63:0] AVG_RECIP =
        ((64'd1 << AVG_SH) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);

    // calibration registers
    logic [CODE_W-1:0] cal_lo_code_reg [2];
    logic [CODE_W-1:0] cal_hi_code_reg [2];
    logic [CODE_W-1:0] cal_lo_temp_reg;
    logic [CODE_W-1:0] cal_hi_temp_reg;

    // channel state
    logic [SUM_W-1:0]   sum_reg  [NUM_CHANNELS];
    logic [SUM_W-1:0]   sum_next [NUM_CHANNELS];
    logic [CNT_W-1:0]   cnt_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]   cnt_next [NUM_CHANNELS];
    logic signed [31:0] last_temp_reg  [NUM_CHANNELS];
    logic signed [31:0] last_temp_next [NUM_CHANNELS];
    logic               seen_reg  [NUM_CHANNELS];
    logic               seen_next [NUM_CHANNELS];
    logic               out_valid_reg, out_valid_next;

    // reading payload
    logic               ch_reg;
    logic [CODE_W-1:0]  avg_reg;
    logic [CORR_W-1:0]  c_lo_reg;
    logic [CORR_W-1:0]  c_hi_reg;
    logic [CORR_W-1:0]  c_avg_reg;
    logic signed [18:0] slope_reg;
    logic signed [32:0] prod_reg;
    logic signed [31:0] t_reg;
    out_word_t          out_reg;

    logic [SUM_W-1:0]      sel_sum;
    logic [CNT_W-1:0]      sel_cnt;
    logic [SUM_W-1:0]      total;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic                  ch_ok;
    logic                  reading;
    logic                  accept;

    logic [CODE_W-1:0]    corr_x;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_busy;
    logic                 div_done;

    logic signed [12:0] dt;
    logic signed [22:0] dt_k;
    logic signed [22:0] dt_sh;
    logic signed [18:0] slope_n;
    logic [19:0]        n_ext;
    logic [19:0]        n_abs;
    logic signed [13:0] den;
    logic [CORR_W-1:0]  den_u;
    logic [20:0]        slope_num;
    logic [18:0]        slope_mag;
    logic [18:0]        slope_val;
    logic               cal_err;

    logic signed [13:0] diff;
    logic signed [32:0] prod_next;
    logic signed [8:0]  off_deg;
    logic signed [18:0] off_mdeg;
    logic signed [33:0] t_sum;
    logic signed [31:0] t_sat;

    logic signed [31:0] max_v;
    logic               max_all;
    out_word_t          out_next;

    assign accept       = sample_valid && cmd.accept;
    assign sample_stall = !cmd.accept;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        sel_sum = '0;
        sel_cnt = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (sample.sensor_channel == 1'(i))
            begin
                sel_sum = sum_reg[i];
                sel_cnt = cnt_reg[i];
            end
        end
    end

    assign ch_ok    = int'(sample.sensor_channel) < NUM_CHANNELS;
    assign total    = sel_sum + SUM_W'(sample.raw_code);
    assign avg_prod = AVG_PROD_W'(total) * AVG_PROD_W'(AVG_RECIP);
    assign reading  = sample_valid && ch_ok && (sel_cnt == CNT_W'(SAMPLES_PER_READING - 1));

    // calibration arithmetic
    assign den     = $signed({1'b0, c_hi_reg}) - $signed({1'b0, c_lo_reg});
    assign den_u   = den[CORR_W-1:0];
    assign cal_err = den[13] || (den == '0);

    assign dt      = $signed({1'b0, cal_hi_temp_reg}) - $signed({1'b0, cal_lo_temp_reg});
    assign dt_k    = 23'(dt) * 23'(MDEG_PER_DEG);
    assign dt_sh   = dt_k >>> TEMP_FRAC_BITS;
    assign slope_n = $signed(dt_sh[18:0]);
    assign n_ext   = {slope_n[18], slope_n};
    assign n_abs   = slope_n[18] ? (~n_ext + 20'd1) : n_ext;
    // floor for a negative dividend: (|n| + d - 1) / d, then negate
    assign slope_num = 21'(n_abs) + (slope_n[18] ? (21'(den_u) - 21'd1) : 21'd0);
    assign slope_mag = div_quo[18:0];
    assign slope_val = slope_n[18] ? (~slope_mag + 19'd1) : slope_mag;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_LO:   corr_x = ch_reg ? cal_lo_code_reg[1] : cal_lo_code_reg[0];
            DIV_HI:   corr_x = ch_reg ? cal_hi_code_reg[1] : cal_hi_code_reg[0];
            default:  corr_x = avg_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SLOPE:
            begin
                div_num = DIV_NUM_W'(slope_num);
                div_den = DIV_DEN_W'(den_u);
            end
            default:
            begin
                div_num = DIV_NUM_W'(CORR_A) * DIV_NUM_W'(corr_x);
                div_den = CORR_SCALE + DIV_DEN_W'(CORR_B) * DIV_DEN_W'(corr_x);
            end
        endcase
    end

    tcac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign diff      = $signed({1'b0, c_avg_reg}) - $signed({1'b0, c_lo_reg});
    assign prod_next = 33'(diff) * 33'(slope_reg);
    assign off_deg   = $signed({1'b0, cal_lo_temp_reg[CODE_W-1:TEMP_FRAC_BITS]})
                       - 9'(DEG_OFFSET);
    assign off_mdeg  = 19'(off_deg) * 19'(MDEG_PER_DEG);
    assign t_sum     = 34'(prod_reg) + 34'(off_mdeg);

    always_comb
    begin
        if (t_sum > T_MAX)
        begin
            t_sat = T_MAX[31:0];
        end
        else if (t_sum < T_MIN)
        begin
            t_sat = T_MIN[31:0];
        end
        else
        begin
            t_sat = t_sum[31:0];
        end
    end

    // maximum over channels with a reading
    always_comb
    begin
        logic any;
        any     = 1'b0;
        max_v   = '0;
        max_all = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (seen_reg[i])
            begin
                if (!any || (last_temp_reg[i] > max_v))
                begin
                    max_v = last_temp_reg[i];
                end
                any = 1'b1;
            end
            else
            begin
                max_all = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next.done_channel      = ch_reg;
        out_next.channel_temp_mdeg = cal_err ? '0 : t_reg;
        out_next.max_temp_mdeg     = max_v;
        out_next.max_valid         = max_all;
        out_next.cal_error         = cal_err;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            sum_next[i]       = sum_reg[i];
            cnt_next[i]       = cnt_reg[i];
            last_temp_next[i] = last_temp_reg[i];
            seen_next[i]      = seen_reg[i];
            if (accept && ch_ok && (sample.sensor_channel == 1'(i)))
            begin
                if (reading)
                begin
                    sum_next[i] = '0;
                    cnt_next[i] = '0;
                end
                else
                begin
                    sum_next[i] = total;
                    cnt_next[i] = cnt_reg[i] + CNT_W'(1);
                end
            end
            if (cmd.update && !cal_err && (ch_reg == 1'(i)))
            begin
                last_temp_next[i] = t_reg;
                seen_next[i]      = 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i]       <= '0;
                cnt_reg[i]       <= '0;
                last_temp_reg[i] <= '0;
                seen_reg[i]      <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i]       <= sum_next[i];
                cnt_reg[i]       <= cnt_next[i];
                last_temp_reg[i] <= last_temp_next[i];
                seen_reg[i]      <= seen_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_lo_code_reg[0] <= '0;
            cal_hi_code_reg[0] <= '1;
            cal_lo_code_reg[1] <= '0;
            cal_hi_code_reg[1] <= '1;
            cal_lo_temp_reg    <= '0;
            cal_hi_temp_reg    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_CODE_CH0:  cal_lo_code_reg[0] <= cfg_data;
                CFG_HIGH_CODE_CH0: cal_hi_code_reg[0] <= cfg_data;
                CFG_LOW_CODE_CH1:  cal_lo_code_reg[1] <= cfg_data;
                CFG_HIGH_CODE_CH1: cal_hi_code_reg[1] <= cfg_data;
                CFG_LOW_TEMP:      cal_lo_temp_reg    <= cfg_data;
                CFG_HIGH_TEMP:     cal_hi_temp_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && reading)
        begin
            avg_reg <= avg_prod[AVG_SH +: CODE_W];
            ch_reg  <= sample.sensor_channel;
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_LO:    c_lo_reg  <= div_quo[CORR_W-1:0];
                DIV_HI:    c_hi_reg  <= div_quo[CORR_W-1:0];
                DIV_CAVG:  c_avg_reg <= div_quo[CORR_W-1:0];
                DIV_SLOPE: slope_reg <= $signed(slope_val);
                default:   ;
            endcase
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.add)
        begin
            t_reg <= t_sat;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        sts.in_reading = reading;
        sts.div_busy   = div_busy;
        sts.div_done   = div_done;
        sts.cal_err    = cal_err;
        sts.out_free   = !out_valid_reg || !result_stall;
    end

endmodule

@@ hw/rtl/tcac_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences accumulation, the four divisions and the result word.
// Depends on tcac_pkg and the assertion macro header.
`include "thermal_code_average_calibrate_defines.svh"
module tcac_ctrl
    import tcac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   in_wait;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (sts.in_reading) state_next = ST_LO_GO;
            ST_LO_GO:      state_next = ST_LO_WAIT;
            ST_LO_WAIT:    if (sts.div_done) state_next = ST_HI_GO;
            ST_HI_GO:      state_next = ST_HI_WAIT;
            ST_HI_WAIT:    if (sts.div_done) state_next = ST_CA_GO;
            ST_CA_GO:      state_next = sts.cal_err ? ST_UPDATE : ST_CA_WAIT;
            ST_CA_WAIT:    if (sts.div_done) state_next = ST_SLOPE_GO;
            ST_SLOPE_GO:   state_next = ST_SLOPE_WAIT;
            ST_SLOPE_WAIT: if (sts.div_done) state_next = ST_MUL;
            ST_MUL:        state_next = ST_ADD;
            ST_ADD:        state_next = ST_UPDATE;
            ST_UPDATE:     state_next = ST_EMIT;
            ST_EMIT:       if (sts.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_sel = DIV_LO;
        case (state_reg)
            ST_IDLE:       cmd.accept = 1'b1;
            ST_LO_GO:
            begin
                cmd.div_sel   = DIV_LO;
                cmd.div_start = 1'b1;
            end
            ST_LO_WAIT:
            begin
                cmd.div_sel   = DIV_LO;
                cmd.div_store = sts.div_done;
            end
            ST_HI_GO:
            begin
                cmd.div_sel   = DIV_HI;
                cmd.div_start = 1'b1;
            end
            ST_HI_WAIT:
            begin
                cmd.div_sel   = DIV_HI;
                cmd.div_store = sts.div_done;
            end
            ST_CA_GO:
            begin
                cmd.div_sel   = DIV_CAVG;
                cmd.div_start = !sts.cal_err;
            end
            ST_CA_WAIT:
            begin
                cmd.div_sel   = DIV_CAVG;
                cmd.div_store = sts.div_done;
            end
            ST_SLOPE_GO:
            begin
                cmd.div_sel   = DIV_SLOPE;
                cmd.div_start = 1'b1;
            end
            ST_SLOPE_WAIT:
            begin
                cmd.div_sel   = DIV_SLOPE;
                cmd.div_store = sts.div_done;
            end
            ST_MUL:        cmd.mul = 1'b1;
            ST_ADD:        cmd.add = 1'b1;
            ST_UPDATE:     cmd.update = 1'b1;
            ST_EMIT:       cmd.emit = sts.out_free;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_wait = (state_reg == ST_LO_WAIT) || (state_reg == ST_HI_WAIT)
                     || (state_reg == ST_CA_WAIT) || (state_reg == ST_SLOPE_WAIT);

    `TCAC_ASSERT(a_start_when_free, clk, rst_n, cmd.div_start |-> !sts.div_busy, "divider restarted while busy")
    `TCAC_ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.div_start, sts.div_busy, "divider did not start")
    `TCAC_ASSERT(a_done_in_wait, clk, rst_n, sts.div_done |-> in_wait, "quotient arrived outside a wait state")
    `TCAC_ASSERT(a_idle_div_quiet, clk, rst_n, cmd.accept |-> !sts.div_busy, "divider busy while taking words")
    `TCAC_ASSERT_NEXT(a_emit_to_idle, clk, rst_n, cmd.emit, cmd.accept, "no return to idle after result word")

endmodule

@@ hw/rtl/thermal_code_average_calibrate.sv @@
`timescale 1ns / 1ps
// Top level of the two-channel thermal code averaging and calibration block.
// Depends on tcac_pkg, tcac_datapath, tcac_ctrl.

// A sample word that does not end a reading is taken without a stall. The word that
// ends a reading (every SAMPLES_PER_READING per channel) has its average formed as it
// is taken, then the sample input stalls while four divisions (three code
// corrections and the slope) share one restoring divider, followed by the
// multiply, add, update and result steps. With a degenerate calibration the correction
// of the average, the slope, the multiply and the add are skipped. The result cycle
// stretches while an earlier result word still waits unaccepted; a finished word
// waits in the output register while the next samples are taken.
module thermal_code_average_calibrate
    import tcac_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 8,
    parameter int NUM_CHANNELS        = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  in_word_t             sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_word_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    cmd_t cmd;
    sts_t sts;

    tcac_datapath #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .NUM_CHANNELS        (NUM_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

    tcac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

endmodule

@@ verif/tb_thermal_code_average_calibrate.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for thermal_code_average_calibrate: random sample words against
// a built-in two-point calibration predictor, across several calibration settings.
// Depends on tcac_pkg and the thermal_code_average_calibrate RTL.
module tb_thermal_code_average_calibrate;
    import tcac_pkg::*;

    localparam int READING_LEN   = 8;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_WORDS   = 155;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam longint MDEG_MAX  = 64'sd2147483647;
    localparam longint MDEG_MIN  = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    in_word_t             sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    out_word_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data = '0;

    in_word_t  pending_samples[$];
    out_word_t due_readings[$];
    int        idle_pct = 11;
    int        mismatches = 0;
    int        cycles = 0;

    // calibration copy and per-channel accumulators
    logic [CODE_W-1:0]  cal_lo_code[2];
    logic [CODE_W-1:0]  cal_hi_code[2];
    logic [CODE_W-1:0]  cal_lo_temp;
    logic [CODE_W-1:0]  cal_hi_temp;
    logic [14:0]        acc_sum[2];
    int unsigned        acc_count[2];
    logic signed [31:0] latest_mdeg[2];
    bit                 mdeg_seen[2];

    thermal_code_average_calibrate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint corrected_code(input logic [CODE_W-1:0] x);
        longint v;
        v = longint'(x);
        return (longint'(CORR_A) * v) / (longint'(CORR_SCALE) + longint'(CORR_B) * v);
    endfunction

    function automatic longint floor_quot(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic void note_cal_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CODE_W-1:0] val);
        case (idx)
            CFG_LOW_CODE_CH0:  cal_lo_code[0] = val;
            CFG_HIGH_CODE_CH0: cal_hi_code[0] = val;
            CFG_LOW_CODE_CH1:  cal_lo_code[1] = val;
            CFG_HIGH_CODE_CH1: cal_hi_code[1] = val;
            CFG_LOW_TEMP:      cal_lo_temp = val;
            CFG_HIGH_TEMP:     cal_hi_temp = val;
            default: ;
        endcase
    endfunction

    // folds one sample word into the accumulators; returns 1 when a reading completes
    function automatic bit predict_reading(input in_word_t w, output out_word_t r);
        bit                 ch;
        logic [CODE_W-1:0]  avg;
        longint             c_avg, c_lo, c_hi, den, slope, t;
        logic signed [31:0] temp, top;
        bit                 any, all;
        ch = w.sensor_channel;
        r = '0;
        acc_sum[ch] = acc_sum[ch] + w.raw_code;
        acc_count[ch]++;
        if (acc_count[ch] < READING_LEN)
            return 1'b0;
        avg = CODE_W'(acc_sum[ch] / READING_LEN);
        acc_sum[ch] = '0;
        acc_count[ch] = 0;
        c_avg = corrected_code(avg);
        c_lo = corrected_code(cal_lo_code[ch]);
        c_hi = corrected_code(cal_hi_code[ch]);
        den = c_hi - c_lo;
        temp = '0;
        if (den > 0)
        begin
            slope = floor_quot(floor_quot((longint'(cal_hi_temp) - longint'(cal_lo_temp))
                                          * MDEG_PER_DEG, longint'(1) << TEMP_FRAC_BITS), den);
            t = (c_avg - c_lo) * slope
                + (longint'(cal_lo_temp >> TEMP_FRAC_BITS) - DEG_OFFSET) * MDEG_PER_DEG;
            if (t > MDEG_MAX)
                t = MDEG_MAX;
            else if (t < MDEG_MIN)
                t = MDEG_MIN;
            temp = t[31:0];
            latest_mdeg[ch] = temp;
            mdeg_seen[ch] = 1'b1;
        end
        top = '0;
        any = 1'b0;
        all = 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            if (mdeg_seen[i])
            begin
                if (!any || latest_mdeg[i] > top)
                    top = latest_mdeg[i];
                any = 1'b1;
            end
            else
            begin
                all = 1'b0;
            end
        end
        r.done_channel = ch;
        r.channel_temp_mdeg = temp;
        r.max_temp_mdeg = top;
        r.max_valid = all;
        r.cal_error = (den <= 0);
        return 1'b1;
    endfunction

    task automatic compare_field(input string label, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t %s: expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        note_cal_write(idx, val);
    endtask

    task automatic program_cal(input logic [CODE_W-1:0] lo0, hi0, lo1, hi1, lot, hit);
        write_reg(CFG_LOW_CODE_CH0, lo0);
        write_reg(CFG_HIGH_CODE_CH0, hi0);
        write_reg(CFG_LOW_CODE_CH1, lo1);
        write_reg(CFG_HIGH_CODE_CH1, hi1);
        write_reg(CFG_LOW_TEMP, lot);
        write_reg(CFG_HIGH_TEMP, hit);
    endtask

    task automatic wait_quiet();
        while (pending_samples.size() != 0 || sample_valid || due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_run(input bit ch, input logic [CODE_W-1:0] code, input int n);
        in_word_t w;
        w.sensor_channel = ch;
        w.raw_code = code;
        repeat (n) pending_samples.push_back(w);
    endtask

    // sample driver
    always @(posedge clk)
    begin : drive_samples
        out_word_t predicted;
        if (sample_valid && !sample_stall)
        begin
            if (predict_reading(sample, predicted))
                due_readings.push_back(predicted);
        end
        if (!sample_valid || !sample_stall)
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                sample <= pending_samples.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch_results
        out_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word: expected none, got %p", $time, result);
            end
            else
            begin
                want = due_readings.pop_front();
                compare_field("done_channel", longint'(want.done_channel),
                              longint'(result.done_channel));
                compare_field("channel_temp_mdeg", longint'(want.channel_temp_mdeg),
                              longint'(result.channel_temp_mdeg));
                compare_field("max_temp_mdeg", longint'(want.max_temp_mdeg),
                              longint'(result.max_temp_mdeg));
                compare_field("max_valid", longint'(want.max_valid),
                              longint'(result.max_valid));
                compare_field("cal_error", longint'(want.cal_error),
                              longint'(result.cal_error));
            end
        end
        result_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_thermal_code_average_calibrate: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CODE_W-1:0] lo[2];
        logic [CODE_W-1:0] hi[2];
        in_word_t          w;
        for (int i = 0; i < 2; i++)
        begin
            cal_lo_code[i] = '0;
            cal_hi_code[i] = '1;
            acc_sum[i] = '0;
            acc_count[i] = 0;
            latest_mdeg[i] = '0;
            mdeg_seen[i] = 1'b0;
        end
        cal_lo_temp = '0;
        cal_hi_temp = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // channel 0 degenerate before anything has been seen: max stays zero until channel 1 has a reading
        write_reg(CFG_LOW_CODE_CH0, 12'd2048);
        write_reg(CFG_HIGH_CODE_CH0, 12'd2048);
        queue_run(1'b0, '1, READING_LEN);
        for (int i = 0; i < READING_LEN; i++)
        begin
            queue_run(1'b1, '0, 1);
            queue_run(1'b0, '0, 1);
        end
        wait_quiet();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            idle_pct = (phase == 5) ? 0 : 11;
            case (phase)
                0: program_cal(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095);
                1: program_cal(12'd1100, 12'd3100, 12'd1000, 12'd3000, 12'd2000, 12'd2960);
                2: program_cal(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0);
                3:
                begin
                    program_cal(12'd4095, 12'd0, 12'd3000, 12'd3000, 12'd2000, 12'd2960);
                    write_reg(CFG_SPARE_LO, CODE_W'($urandom_range(0, 4095)));
                    write_reg(CFG_SPARE_HI, CODE_W'($urandom_range(0, 4095)));
                end
                4: program_cal(12'd0, 12'd1, 12'd4094, 12'd4095, 12'd0, 12'd4095);
                default:
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        lo[c] = CODE_W'($urandom_range(0, 2047));
                        hi[c] = CODE_W'($urandom_range(2048, 4095));
                        case ($urandom_range(0, 7))
                            0: hi[c] = lo[c];
                            1: {lo[c], hi[c]} = {hi[c], lo[c]};
                            default: ;
                        endcase
                    end
                    program_cal(lo[0], hi[0], lo[1], hi[1],
                                CODE_W'($urandom_range(0, 4095)),
                                CODE_W'($urandom_range(0, 4095)));
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                w.sensor_channel = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0: w.raw_code = '0;
                    1: w.raw_code = '1;
                    default: w.raw_code = CODE_W'($urandom_range(0, 4095));
                endcase
                pending_samples.push_back(w);
            end
            wait_quiet();
        end

        if (mismatches == 0)
            $display("tb_thermal_code_average_calibrate: done, clean");
        else
            $display("tb_thermal_code_average_calibrate: done, errors");
        $finish;
    end

endmodule
